FILE: rtl/bht_pkg.sv
// Shared types and constants for the bucketed hash table.
// No dependencies; bht_front, bht_back and bucketed_hash_table import this package.
`default_nettype none

package bht_pkg;

    // Fixed field widths of a request and a result
    localparam int KEY_BITS       = 31;
    localparam int REQ_VALUE_BITS = 32;
    localparam int STATUS_BITS    = 3;

    // Parameter defaults for the top level
    localparam int NUM_BUCKETS_DEF      = 16;
    localparam int SLOTS_PER_BUCKET_DEF = 4;
    localparam int VALUE_BITS_DEF       = 32;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_ADDED     = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic                      kind;
        logic [KEY_BITS-1:0]       req_key;
        logic [REQ_VALUE_BITS-1:0] req_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   table_empty;
    } rsp_t;

    localparam int REQ_BITS = $bits(req_t);

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/bht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/bht_fifo.sv
// Small register queue between the front and back parts of the hash table.
// No package dependency; DEPTH must be a power of two.
`default_nettype none

module bht_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Hold queued transactions
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (level_reg == '0);
    assign level    = level_reg;

endmodule

`default_nettype wire

FILE: rtl/bht_front.sv
// Front part: accepts requests and works out the bucket (key mod NUM_BUCKETS).
// Depends on bht_pkg; pushes classified requests into bht_fifo.
`default_nettype none

module bht_front #(
    parameter int NUM_BUCKETS = bht_pkg::NUM_BUCKETS_DEF,
    parameter int BKT_W       = $clog2(NUM_BUCKETS)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire bht_pkg::req_t                  req,
    input  wire logic [bht_pkg::LEVEL_BITS-1:0] queue_level,
    output logic                                push,
    output logic      [BKT_W-1:0]               push_bucket,
    output bht_pkg::req_t                       push_req
);

    import bht_pkg::*;

    // Reciprocal of the bucket count; the estimated quotient is low by at most one
    localparam logic [63:0]         RECIP_FULL =
        (64'd1 << KEY_BITS) / NUM_BUCKETS;
    localparam logic [KEY_BITS-1:0] RECIP = RECIP_FULL[KEY_BITS-1:0];
    localparam logic [BKT_W:0]      NB    = (BKT_W+1)'(NUM_BUCKETS);

    logic                  accept;
    logic [2*KEY_BITS-1:0] prod;
    logic [KEY_BITS-1:0]   quot_next;

    logic                  s1_valid_reg, s1_valid_next;
    req_t                  s1_req_reg;
    logic [KEY_BITS-1:0]   s1_quot_reg;

    logic [KEY_BITS-1:0]   qn;
    logic [KEY_BITS-1:0]   rem;
    logic [BKT_W:0]        rem_lo;
    logic [BKT_W:0]        rem_fix;

    // Stall while the queue plus the stage in flight could overflow
    assign busy = ((LEVEL_BITS+1)'(queue_level) + (LEVEL_BITS+1)'(s1_valid_reg))
                  >= (LEVEL_BITS+1)'(QUEUE_DEPTH);
    assign accept = start && !busy;

    // Stage 1: estimate the quotient by reciprocal multiplication
    assign prod          = {{KEY_BITS{1'b0}}, req.req_key} * {{KEY_BITS{1'b0}}, RECIP};
    assign quot_next     = prod[2*KEY_BITS-1:KEY_BITS];
    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req;
            s1_quot_reg <= quot_next;
        end
    end

    // Stage 2: remainder with one corrective subtract, then push
    assign qn      = KEY_BITS'(s1_quot_reg * KEY_BITS'(NUM_BUCKETS));
    assign rem     = s1_req_reg.req_key - qn;
    assign rem_lo  = rem[BKT_W:0];
    assign rem_fix = (rem_lo >= NB) ? (rem_lo - NB) : rem_lo;

    assign push        = s1_valid_reg;
    assign push_bucket = rem_fix[BKT_W-1:0];
    assign push_req    = s1_req_reg;

endmodule

`default_nettype wire

FILE: rtl/bht_back.sv
// Back part: read-modify-write of one bucket row per request, result output.
// Depends on bht_pkg and bht_ram; pops requests from bht_fifo.
`default_nettype none

module bht_back #(
    parameter int NUM_BUCKETS      = bht_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int VALUE_BITS       = bht_pkg::VALUE_BITS_DEF,
    parameter int BKT_W            = $clog2(NUM_BUCKETS)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                queue_empty,
    input  wire logic [BKT_W+bht_pkg::REQ_BITS-1:0]  queue_data,
    output logic                                     pop,
    output logic                                     done,
    output bht_pkg::rsp_t                            rsp
);

    import bht_pkg::*;

    localparam int ENT_W = KEY_BITS + VALUE_BITS;
    localparam int ROW_W = SLOTS_PER_BUCKET * ENT_W;
    localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int CNT_W = $clog2(TOTAL + 1);

    back_state_t                 state_reg, state_next;
    logic [BKT_W-1:0]            bkt_reg, bkt_next;
    req_t                        cur_reg, cur_next;
    logic [SLOTS_PER_BUCKET-1:0] valid_reg [NUM_BUCKETS];
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        done_reg, done_next;
    rsp_t                        rsp_reg, rsp_next;

    logic [BKT_W-1:0]            q_bkt;
    req_t                        q_req;
    logic                        ram_re;
    logic                        ram_we;
    logic [ROW_W-1:0]            row_rd;
    logic [ROW_W-1:0]            row_wr;

    logic [SLOTS_PER_BUCKET-1:0] vrow;
    logic [SLOTS_PER_BUCKET-1:0] vrow_next;
    logic                        valid_we;
    logic [SLOTS_PER_BUCKET-1:0] hit_vec;
    logic [SLOTS_PER_BUCKET-1:0] hit_oh;
    logic [SLOTS_PER_BUCKET-1:0] free_vec;
    logic [SLOTS_PER_BUCKET-1:0] free_oh;
    logic                        do_add;
    logic                        do_repl;
    logic                        do_rem;
    logic [VALUE_BITS-1:0]       new_val;

    assign q_bkt = queue_data[BKT_W+REQ_BITS-1:REQ_BITS];
    assign q_req = queue_data[REQ_BITS-1:0];

    // Bucket rows: keys and values of every slot
    bht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bkt_reg),
        .wdata (row_wr),
        .re    (ram_re),
        .raddr (q_bkt),
        .rdata (row_rd)
    );

    // Keep the stored value to VALUE_BITS bits
    generate
        if (VALUE_BITS <= REQ_VALUE_BITS)
        begin : g_val_trunc
            assign new_val = cur_reg.req_value[VALUE_BITS-1:0];
        end
        else
        begin : g_val_ext
            assign new_val = {{(VALUE_BITS-REQ_VALUE_BITS){1'b0}}, cur_reg.req_value};
        end
    endgenerate

    // Compare all slots of the bucket in parallel
    always_comb
    begin
        vrow = valid_reg[bkt_reg];
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            hit_vec[s] = vrow[s] && (row_rd[s*ENT_W +: KEY_BITS] == cur_reg.req_key);
        end
        free_vec = ~vrow;
        hit_oh   = hit_vec & (~hit_vec + 1'b1);
        free_oh  = free_vec & (~free_vec + 1'b1);
    end

    // Build the row to write back
    always_comb
    begin
        row_wr = row_rd;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (do_add && free_oh[s])
            begin
                row_wr[s*ENT_W +: KEY_BITS] = cur_reg.req_key;
            end
            if ((do_add && free_oh[s]) || (do_repl && hit_oh[s]))
            begin
                row_wr[s*ENT_W+KEY_BITS +: VALUE_BITS] = new_val;
            end
        end
    end

    // Sequencer: pop and read together in BK_IDLE, then decide and write back in BK_EXEC
    always_comb
    begin
        state_next = state_reg;
        bkt_next   = bkt_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        pop        = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        valid_we   = 1'b0;
        vrow_next  = vrow;
        do_add     = 1'b0;
        do_repl    = 1'b0;
        do_rem     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    ram_re     = 1'b1;
                    bkt_next   = q_bkt;
                    cur_next   = q_req;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (cur_reg.kind == KIND_INSERT)
                begin
                    if (hit_vec != '0)
                    begin
                        do_repl         = 1'b1;
                        rsp_next.status = ST_REPLACED;
                    end
                    else if (free_vec != '0)
                    begin
                        do_add          = 1'b1;
                        rsp_next.status = ST_ADDED;
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                end
                else
                begin
                    if (hit_vec != '0)
                    begin
                        do_rem          = 1'b1;
                        rsp_next.status = ST_REMOVED;
                    end
                    else
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                end
                ram_we = do_add || do_repl;
                if (do_add)
                begin
                    valid_we   = 1'b1;
                    vrow_next  = vrow | free_oh;
                    count_next = count_reg + 1'b1;
                end
                else if (do_rem)
                begin
                    valid_we   = 1'b1;
                    vrow_next  = vrow & ~hit_oh;
                    count_next = count_reg - 1'b1;
                end
                rsp_next.table_empty = (count_next == '0);
                done_next            = 1'b1;
                state_next           = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Valid marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else if (valid_we)
        begin
            valid_reg[bkt_reg] <= vrow_next;
        end
    end

    // Hold the transaction under work and the result
    always_ff @(posedge clk)
    begin
        bkt_reg <= bkt_next;
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == BK_EXEC))
        else $error("result strobe without a completed bucket update");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TOTAL))
        else $error("entry count exceeds the slot total");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp_reg.table_empty == (count_reg == '0)))
        else $error("empty flag disagrees with the entry count");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == ST_ADDED) |->
            (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("add did not bump the entry count");

    a_remove_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == ST_REMOVED) |->
            (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("remove did not drop the entry count");
`endif

endmodule

`default_nettype wire

FILE: rtl/bucketed_hash_table.sv
// A request passes the front's reciprocal pipeline, the queue, then the back end's
// BK_IDLE and BK_EXEC states; done and rsp are registered outputs.
// The back end takes a new request only after the last one's bucket-row
// read-modify-write (a RAM read in BK_IDLE, compare and write in BK_EXEC).
// The front computes key mod NUM_BUCKETS in a 2-stage reciprocal pipeline and
// queues up to 4 requests; busy rises when the queue could overflow.
// Reset clears valid marks, entry count and queue at once; no clearing pass.
// Results cannot be stalled by the receiver.
`default_nettype none

module bucketed_hash_table #(
    parameter int NUM_BUCKETS      = bht_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int VALUE_BITS       = bht_pkg::VALUE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire bht_pkg::req_t req,
    output logic               done,
    output bht_pkg::rsp_t      rsp
);

    import bht_pkg::*;

    localparam int BKT_W = $clog2(NUM_BUCKETS);
    localparam int Q_W   = BKT_W + REQ_BITS;

    logic                  push;
    logic [BKT_W-1:0]      push_bucket;
    req_t                  push_req;
    logic                  pop;
    logic [Q_W-1:0]        pop_data;
    logic                  queue_empty;
    logic [LEVEL_BITS-1:0] queue_level;

    // Accept and classify
    bht_front #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BKT_W       (BKT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .queue_level (queue_level),
        .push        (push),
        .push_bucket (push_bucket),
        .push_req    (push_req)
    );

    // Decouple front and back
    bht_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_bucket, push_req}),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty),
        .level     (queue_level)
    );

    // Carry out table updates
    bht_back #(
        .NUM_BUCKETS      (NUM_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .VALUE_BITS       (VALUE_BITS),
        .BKT_W            (BKT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .done        (done),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

FILE: test/bht_checker.sv
// Response checker for the bucketed hash table: predicts each result from the
// accepted requests and compares it with what the block returns. Needs bht_pkg.
`default_nettype none

module bht_checker #(
    parameter int NUM_BUCKETS      = bht_pkg::NUM_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int VALUE_BITS       = bht_pkg::VALUE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire bht_pkg::req_t req,
    input  wire logic          done,
    input  wire bht_pkg::rsp_t rsp,
    output int                 mismatch_count,
    output int                 rsp_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bht_pkg::*;

    localparam int TOTAL_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;

    // Shadow copy of the table
    logic [KEY_BITS-1:0]   shadow_key   [TOTAL_SLOTS];
    logic [VALUE_BITS-1:0] shadow_value [TOTAL_SLOTS];
    logic                  shadow_valid [TOTAL_SLOTS];
    int                    shadow_count;

    rsp_t rsp_due_q[$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        $display("bht_checker: mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Apply one transaction to the shadow table and return the response it earns
    function automatic rsp_t table_update(input req_t r);
        int   base;
        int   hit;
        int   free_slot;
        rsp_t o;
        base      = (int'(r.req_key) % NUM_BUCKETS) * SLOTS_PER_BUCKET;
        hit       = -1;
        free_slot = -1;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--)
        begin
            if (shadow_valid[base + s] && shadow_key[base + s] == r.req_key)
                hit = s;
            if (!shadow_valid[base + s])
                free_slot = s;
        end
        if (r.kind == KIND_INSERT)
        begin
            if (hit >= 0)
            begin
                shadow_value[base + hit] = r.req_value[VALUE_BITS-1:0];
                o.status = ST_REPLACED;
            end
            else if (free_slot >= 0)
            begin
                shadow_key[base + free_slot]   = r.req_key;
                shadow_value[base + free_slot] = r.req_value[VALUE_BITS-1:0];
                shadow_valid[base + free_slot] = 1'b1;
                shadow_count++;
                o.status = ST_ADDED;
            end
            else
                o.status = ST_FULL;
        end
        else
        begin
            if (hit >= 0)
            begin
                shadow_valid[base + hit] = 1'b0;
                shadow_count--;
                o.status = ST_REMOVED;
            end
            else
                o.status = ST_NOT_FOUND;
        end
        o.table_empty = (shadow_count == 0);
        return o;
    endfunction

    // Retire results against the oldest prediction, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_SLOTS; i++)
                shadow_valid[i] = 1'b0;
            shadow_count = 0;
            rsp_due_q.delete();
            rsp_pending <= 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (rsp_due_q.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = rsp_due_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp.status, want.status));
                    if (rsp.table_empty !== want.table_empty)
                        report_mismatch($sformatf("table_empty got %0b want %0b",
                                                  rsp.table_empty, want.table_empty));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                rsp_due_q.push_back(table_update(req));
            rsp_pending <= rsp_due_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Top of the bucketed hash table testbench: clock, reset, directed and random
// request stimulus, and the verdict. Needs bht_pkg, bucketed_hash_table, bht_checker.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bht_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int POOL_SIZE    = 96;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   mismatch_count;
    int   rsp_pending;

    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                  calm_left;

    bucketed_hash_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    bht_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .rsp_pending    (rsp_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

    function automatic req_t make_req(input logic k, input logic [KEY_BITS-1:0] key,
                                      input logic [REQ_VALUE_BITS-1:0] value);
        req_t r;
        r.kind      = k;
        r.req_key   = key;
        r.req_value = value;
        return r;
    endfunction

    // Idle cycles after a transaction: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if (roll < 3)
            calm_left = $urandom_range(20, 60);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one transaction, hold it until accepted, then idle
    task automatic send_req(input req_t r);
        int gap;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (rsp_pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        req_t                directed[$];
        logic [KEY_BITS-1:0] key;
        int                  insert_pct;
        int                  roll;

        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        calm_left = 0;

        // Keys clustered six per bucket so buckets fill and overflow
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key = KEY_BITS'($urandom);
            key = key - KEY_BITS'(key % bht_pkg::NUM_BUCKETS_DEF)
                      + KEY_BITS'(i % bht_pkg::NUM_BUCKETS_DEF);
            key_pool[i] = key;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty remove, replace, full bucket, lowest free slot, drain
        directed.push_back(make_req(KIND_REMOVE, 31'd0, 32'h0));
        directed.push_back(make_req(KIND_INSERT, 31'd0, 32'h0));
        directed.push_back(make_req(KIND_INSERT, 31'd0, 32'hFFFF_FFFF));
        directed.push_back(make_req(KIND_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
        directed.push_back(make_req(KIND_INSERT, 31'd16, 32'hA5A5_5A5A));
        directed.push_back(make_req(KIND_INSERT, 31'd32, 32'h5A5A_A5A5));
        directed.push_back(make_req(KIND_INSERT, 31'd48, 32'h0000_0001));
        directed.push_back(make_req(KIND_INSERT, 31'd64, 32'h8000_0000));
        directed.push_back(make_req(KIND_REMOVE, 31'd16, 32'hFFFF_FFFF));
        directed.push_back(make_req(KIND_INSERT, 31'd64, 32'h1234_5678));
        directed.push_back(make_req(KIND_INSERT, 31'd80, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'd16, 32'h0));
        directed.push_back(make_req(KIND_INSERT, 31'd64, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'h7FFF_FFEF, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'd0, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'd32, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'd48, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'd64, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'h7FFF_FFFF, 32'h0));
        directed.push_back(make_req(KIND_REMOVE, 31'h7FFF_FFFF, 32'h0));
        directed.push_back(make_req(KIND_INSERT, 31'h7FFF_FFF0, 32'hDEAD_BEEF));
        directed.push_back(make_req(KIND_REMOVE, 31'h7FFF_FFF0, 32'h0));
        foreach (directed[i])
            send_req(directed[i]);

        // Random: insert bias changes every hundred transactions
        insert_pct = 60;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                insert_pct = 30 + 20 * $urandom_range(0, 2);
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 10)
                key = KEY_BITS'($urandom);
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_req(make_req(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT
                                                                   : KIND_REMOVE,
                              key, $urandom));
        end

        // Let the last results come home
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && rsp_pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: bucketed_hash_table.f
rtl/bht_pkg.sv
rtl/bht_ram.sv
rtl/bht_fifo.sv
rtl/bht_front.sv
rtl/bht_back.sv
rtl/bucketed_hash_table.sv
test/bht_checker.sv
test/tb_top.sv
